// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants shared by the rational arithmetic unit modules.
// ----------------------------------------------------------------------------
package rau_pkg;

   typedef enum logic [3:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_MUL = 4'd2,
      OP_DIV = 4'd3,
      OP_LT  = 4'd4,
      OP_LE  = 4'd5,
      OP_EQ  = 4'd6,
      OP_NE  = 4'd7,
      OP_GE  = 4'd8,
      OP_GT  = 4'd9
   } op_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef struct packed {
      logic [3:0]         op;
      logic signed [31:0] a_num;
      logic [30:0]        a_den;
      logic signed [31:0] b_num;
      logic [30:0]        b_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_num;
      logic [30:0]        res_den;
      logic               truth;
      logic [1:0]         status;
   } rsp_type;

   // Divider handshake: start with operands, done with quotient/remainder.
   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quo;
      logic [63:0] rem;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_G1_DIV,
      S_G1_WAIT,
      S_G1_STEP,
      S_G2_DIV,
      S_G2_WAIT,
      S_G2_STEP,
      S_Q_DIV,
      S_Q_WAIT,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_COMBINE,
      S_RG_DIV,
      S_RG_WAIT,
      S_RG_STEP,
      S_RN_DIV,
      S_RN_WAIT,
      S_RD_DIV,
      S_RD_WAIT,
      S_FINISH,
      S_DONE
   } state_type;

endpackage

// ----- rtl/rau_div.sv -----
// ----------------------------------------------------------------------------
// rau_div
// Shared 64-bit unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::div_req_type dreq,
   output rau_pkg::div_rsp_type drsp
);
   import rau_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[63]} - {1'b0, dsr_ff};
      if (dreq.start && !busy_ff) begin
         quo_in  = dreq.dividend;
         rem_in  = '0;
         dsr_in  = dreq.divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign drsp.busy = busy_ff;
   assign drsp.done = done_ff;
   assign drsp.quo  = quo_ff;
   assign drsp.rem  = rem_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("busy with done");
   a_cnt_zero_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> cnt_ff == 7'd0) else $error("count nonzero when idle");
`endif

endmodule

// ----- rtl/rational_arithmetic_unit_core.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Rational add/sub/mul/div/compare with gcd reduction on a shared divider.
// ----------------------------------------------------------------------------
// An unused op, a zero denominator or a divide by zero goes from S_CHECK
// straight to S_DONE and the strobe; otherwise each Euclid step and each exact
// quotient is one pass of the shared divider.
// Throughput: one item at a time; busy is high from accept until the strobe
// cycle, in which the next item can already be taken.
// Reset: synchronous, active high; clears sequencer and divider control.
// The result strobe lasts one cycle; the receiver cannot stall.
module rational_arithmetic_unit_core #(
   parameter int WORD_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req_item,
   output logic             rsp_strobe,
   output rau_pkg::rsp_type rsp_item
);
   import rau_pkg::*;

   localparam logic [63:0] Lim = (64'd1 << (WORD_BITS - 1)) - 64'd1;

   state_type state_ff, state_in;

   logic [3:0]  op_ff, op_in;
   logic        an_neg_ff, an_neg_in;
   logic        bn_neg_ff, bn_neg_in;
   logic [63:0] an_ff, an_in;   // magnitudes
   logic [63:0] ad_ff, ad_in;
   logic [63:0] bn_ff, bn_in;
   logic [63:0] bd_ff, bd_in;
   logic [63:0] x_ff, x_in;     // euclid pair
   logic [63:0] y_ff, y_in;
   logic [63:0] g1_ff, g1_in;
   logic [63:0] g2_ff, g2_in;
   logic [63:0] rn_ff, rn_in;   // result magnitudes
   logic [63:0] rd_ff, rd_in;
   logic        rneg_ff, rneg_in;
   logic [2:0]  qi_ff, qi_in;
   rsp_type     rsp_ff, rsp_in;
   logic        strobe_ff, strobe_in;

   div_req_type dreq;
   div_rsp_type drsp;
   logic [63:0] mul_a, mul_b, mul_p;
   logic [64:0] sx, sy;
   logic [65:0] sum;
   logic        xy_lt, xy_eq;
   logic        is_md;

   rau_div u_div (
      .clock (clock),
      .reset (reset),
      .dreq  (dreq),
      .drsp  (drsp)
   );

   // single shared 32x32 multiplier; operands always fit 32 bits
   assign mul_p = mul_a[31:0] * mul_b[31:0];
   assign is_md = (op_ff == OP_MUL) || (op_ff == OP_DIV);

   always_comb begin
      sx    = an_neg_ff ? -{1'b0, x_ff} : {1'b0, x_ff};
      sy    = bn_neg_ff ? -{1'b0, y_ff} : {1'b0, y_ff};
      xy_lt = $signed(sx) < $signed(sy);
      xy_eq = sx == sy;
      sum   = (op_ff == OP_SUB) ? {sx[64], sx} - {sy[64], sy}
                                : {sx[64], sx} + {sy[64], sy};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (start) state_in = S_CHECK;
         S_CHECK: begin
            if (op_ff > OP_GT || ad_ff == '0 || bd_ff == '0 ||
                (op_ff == OP_DIV && bn_ff == '0))
               state_in = S_DONE;
            else
               state_in = S_G1_STEP;
         end
         S_G1_STEP: state_in = (y_ff == '0) ? (is_md ? S_G2_STEP : S_Q_DIV) : S_G1_DIV;
         S_G1_DIV:  state_in = S_G1_WAIT;
         S_G1_WAIT: if (drsp.done) state_in = S_G1_STEP;
         S_G2_STEP: state_in = (y_ff == '0) ? S_Q_DIV : S_G2_DIV;
         S_G2_DIV:  state_in = S_G2_WAIT;
         S_G2_WAIT: if (drsp.done) state_in = S_G2_STEP;
         S_Q_DIV:   state_in = S_Q_WAIT;
         S_Q_WAIT: begin
            if (drsp.done)
               state_in = ((is_md && qi_ff == 3'd3) || (!is_md && qi_ff == 3'd1))
                          ? S_MUL1 : S_Q_DIV;
         end
         S_MUL1:    state_in = S_MUL2;
         S_MUL2:    state_in = is_md ? S_COMBINE : S_MUL3;
         S_MUL3:    state_in = S_COMBINE;
         S_COMBINE: state_in = (op_ff >= OP_LT) ? S_DONE : S_RG_STEP;
         S_RG_STEP: state_in = (y_ff == '0) ? (x_ff == '0 ? S_FINISH : S_RN_DIV) : S_RG_DIV;
         S_RG_DIV:  state_in = S_RG_WAIT;
         S_RG_WAIT: if (drsp.done) state_in = S_RG_STEP;
         S_RN_DIV:  state_in = S_RN_WAIT;
         S_RN_WAIT: if (drsp.done) state_in = S_RD_DIV;
         S_RD_DIV:  state_in = S_RD_WAIT;
         S_RD_WAIT: if (drsp.done) state_in = S_FINISH;
         S_FINISH:  state_in = S_DONE;
         S_DONE:    state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      op_in     = op_ff;
      an_neg_in = an_neg_ff;
      bn_neg_in = bn_neg_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      x_in = x_ff; y_in = y_ff; g1_in = g1_ff; g2_in = g2_ff;
      rn_in = rn_ff; rd_in = rd_ff; rneg_in = rneg_ff; qi_in = qi_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      dreq      = '0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_item.op;
               an_neg_in = req_item.a_num[31];
               bn_neg_in = req_item.b_num[31];
               an_in = req_item.a_num[31] ? 64'(-{1'b0, req_item.a_num})
                                          : 64'(req_item.a_num);
               bn_in = req_item.b_num[31] ? 64'(-{1'b0, req_item.b_num})
                                          : 64'(req_item.b_num);
               an_in = {32'd0, an_in[31:0]};
               bn_in = {32'd0, bn_in[31:0]};
               ad_in = {33'd0, req_item.a_den};
               bd_in = {33'd0, req_item.b_den};
               rsp_in = '{res_num: '0, res_den: 31'd1, truth: 1'b0, status: ST_OK};
            end
         end
         S_CHECK: begin
            qi_in = '0;
            if (op_ff > OP_GT) begin
               rsp_in.status = ST_OK;
            end else if (ad_ff == '0 || bd_ff == '0 ||
                         (op_ff == OP_DIV && bn_ff == '0)) begin
               rsp_in.status = ST_DIV0;
            end else if (op_ff == OP_DIV) begin
               // swap b to its reciprocal; sign stays on numerator
               bn_in = bd_ff;
               bd_in = bn_ff;
               x_in  = an_ff;
               y_in  = bn_ff;
            end else if (op_ff == OP_MUL) begin
               x_in = an_ff;
               y_in = bd_ff;
            end else begin
               x_in = ad_ff;
               y_in = bd_ff;
            end
         end
         S_G1_DIV, S_G2_DIV, S_RG_DIV: begin
            dreq = '{start: 1'b1, dividend: x_ff, divisor: y_ff};
         end
         S_G1_WAIT, S_G2_WAIT, S_RG_WAIT: begin
            if (drsp.done) begin
               x_in = y_ff;
               y_in = drsp.rem;
            end
         end
         S_G1_STEP: begin
            if (y_ff == '0) begin
               g1_in = (x_ff == '0) ? 64'd1 : x_ff;
               x_in  = bn_ff;
               y_in  = ad_ff;
            end
         end
         S_G2_STEP: begin
            if (y_ff == '0) g2_in = (x_ff == '0) ? 64'd1 : x_ff;
         end
         S_Q_DIV: begin
            // md: an/g1, bn/g2, ad/g2, bd/g1; else bd/g, ad/g
            unique case (qi_ff)
               3'd0:    dreq = '{start: 1'b1, dividend: is_md ? an_ff : bd_ff,
                                 divisor: g1_ff};
               3'd1:    dreq = '{start: 1'b1, dividend: is_md ? bn_ff : ad_ff,
                                 divisor: g1_ff};
               3'd2:    dreq = '{start: 1'b1, dividend: ad_ff, divisor: g2_ff};
               default: dreq = '{start: 1'b1, dividend: bd_ff, divisor: g1_ff};
            endcase
            if (is_md && qi_ff == 3'd1) dreq.divisor = g2_ff;
         end
         S_Q_WAIT: begin
            if (drsp.done) begin
               qi_in = qi_ff + 3'd1;
               if (is_md) begin
                  unique case (qi_ff)
                     3'd0:    x_in = drsp.quo;   // n1
                     3'd1:    y_in = drsp.quo;   // n2
                     3'd2:    rn_in = drsp.quo;  // d1
                     default: rd_in = drsp.quo;  // d2
                  endcase
               end else begin
                  if (qi_ff == 3'd0) g2_in = drsp.quo;  // ma
                  else               rd_in = drsp.quo;  // mb
               end
            end
         end
         S_MUL1: begin
            if (is_md) begin
               mul_a = x_ff; mul_b = y_ff; x_in = mul_p;
            end else begin
               mul_a = an_ff; mul_b = g2_ff; x_in = mul_p;
            end
         end
         S_MUL2: begin
            if (is_md) begin
               mul_a = rn_ff; mul_b = rd_ff; y_in = mul_p;
            end else begin
               mul_a = bn_ff; mul_b = rd_ff; y_in = mul_p;
            end
         end
         S_MUL3: begin
            mul_a = ad_ff; mul_b = g2_ff; g1_in = mul_p;  // common den
         end
         S_COMBINE: begin
            if (is_md) begin
               rneg_in = an_neg_ff ^ bn_neg_ff;
               x_in    = x_ff;
               y_in    = y_ff;
               rn_in   = x_ff;
               rd_in   = y_ff;
               if (x_ff == '0) rneg_in = 1'b0;
            end else if (op_ff >= OP_LT) begin
               unique case (op_ff)
                  OP_LT:   rsp_in.truth = xy_lt;
                  OP_LE:   rsp_in.truth = xy_lt || xy_eq;
                  OP_EQ:   rsp_in.truth = xy_eq;
                  OP_NE:   rsp_in.truth = !xy_eq;
                  OP_GE:   rsp_in.truth = !xy_lt;
                  default: rsp_in.truth = !xy_lt && !xy_eq;
               endcase
            end else begin
               rneg_in = sum[65];
               rn_in   = sum[65] ? 64'(-sum) : sum[63:0];
               rd_in   = g1_ff;
               x_in    = sum[65] ? 64'(-sum) : sum[63:0];
               y_in    = g1_ff;
            end
            if (is_md) begin
               x_in = x_ff;
               y_in = y_ff;
            end
         end
         S_RG_STEP: begin
            if (y_ff == '0) g1_in = x_ff;
         end
         S_RN_DIV: dreq = '{start: 1'b1, dividend: rn_ff, divisor: g1_ff};
         S_RN_WAIT: if (drsp.done) rn_in = drsp.quo;
         S_RD_DIV: dreq = '{start: 1'b1, dividend: rd_ff, divisor: g1_ff};
         S_RD_WAIT: if (drsp.done) rd_in = drsp.quo;
         S_FINISH: begin
            if (rn_ff == '0) begin
               rsp_in = '{res_num: '0, res_den: 31'd1, truth: 1'b0, status: ST_OK};
            end else if (rn_ff > Lim || rd_ff > Lim || rd_ff == '0) begin
               rsp_in = '{res_num: '0, res_den: 31'd1, truth: 1'b0, status: ST_OVF};
            end else begin
               rsp_in.res_num = rneg_ff ? -rn_ff[31:0] : rn_ff[31:0];
               rsp_in.res_den = rd_ff[30:0];
               rsp_in.truth   = 1'b0;
               rsp_in.status  = ST_OK;
            end
         end
         S_DONE: strobe_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; an_neg_ff <= an_neg_in; bn_neg_ff <= bn_neg_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      x_ff <= x_in; y_ff <= y_in; g1_ff <= g1_in; g2_ff <= g2_in;
      rn_ff <= rn_in; rd_ff <= rd_in; rneg_ff <= rneg_in; qi_ff <= qi_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef SYNTHESIS
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_DONE) else $error("stray strobe");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accept did not go busy");
   a_rsp_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_item.res_den != '0) else $error("zero denominator");
   a_div_idle_on_issue: assert property (@(posedge clock) disable iff (reset)
      dreq.start |-> !drsp.busy) else $error("divider reissued while busy");
`endif

endmodule

// ----- dv/rational_arithmetic_unit_core_test.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_test
// Drives rational operations through the core and checks every result
// against an in-bench predictor of the exact reduced value, status and truth.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   localparam longint unsigned LIM = 64'h7FFF_FFFF;

   // Euclid on magnitudes
   function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic longint unsigned mag64(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic rsp_type make_rsp(longint num, longint unsigned den, bit t,
                                        logic [1:0] st);
      rsp_type r;
      r.res_num = num[31:0];
      r.res_den = den[30:0];
      r.truth = t;
      r.status = st;
      return r;
   endfunction

   function automatic rsp_type reduce_rational(longint num, longint den);
      bit neg;
      longint unsigned n, d, g;
      neg = (num < 0) != (den < 0);
      n = mag64(num);
      d = mag64(den);
      g = gcd64(n, d);
      if (g != 0) begin
         n = n / g;
         d = d / g;
      end
      if (n == 0) d = 1;
      if (n > LIM || d > LIM || d == 0) return make_rsp(0, 1, 0, ST_OVF);
      return make_rsp(neg ? -longint'(n) : longint'(n), d, 0, ST_OK);
   endfunction

   function automatic rsp_type predict_rational(req_type q);
      longint an, bn, x, y, n1, n2, d1, d2, g1, g2, tmp;
      longint unsigned ad, bd, g, ma, mb;
      bit t;
      an = longint'(q.a_num);
      bn = longint'(q.b_num);
      ad = q.a_den;
      bd = q.b_den;
      if (q.op > OP_GT) return make_rsp(0, 1, 0, ST_OK);
      if (ad == 0 || bd == 0) return make_rsp(0, 1, 0, ST_DIV0);
      if (q.op == OP_MUL || q.op == OP_DIV) begin
         if (q.op == OP_DIV) begin
            if (bn == 0) return make_rsp(0, 1, 0, ST_DIV0);
            tmp = longint'(bd);
            bd = mag64(bn);
            bn = bn < 0 ? -tmp : tmp;
         end
         g1 = longint'(gcd64(mag64(an), bd));
         g2 = longint'(gcd64(mag64(bn), ad));
         if (g1 == 0) g1 = 1;
         if (g2 == 0) g2 = 1;
         n1 = an / g1;
         n2 = bn / g2;
         d1 = longint'(ad) / g2;
         d2 = longint'(bd) / g1;
         return reduce_rational(n1 * n2, d1 * d2);
      end
      g = gcd64(ad, bd);
      ma = bd / g;
      mb = ad / g;
      x = an * longint'(ma);
      y = bn * longint'(mb);
      case (q.op)
         OP_ADD: return reduce_rational(x + y, longint'(ad) * longint'(ma));
         OP_SUB: return reduce_rational(x - y, longint'(ad) * longint'(ma));
         OP_LT: t = x < y;
         OP_LE: t = x <= y;
         OP_EQ: t = x == y;
         OP_NE: t = x != y;
         OP_GE: t = x >= y;
         default: t = x > y;
      endcase
      return make_rsp(0, 1, t, ST_OK);
   endfunction

   class rational_scoreboard;
      rsp_type pending[$];
      int errors = 0;

      function void note_request(req_type q);
         pending.push_back(predict_rational(q));
      endfunction

      function void check_result(rsp_type r);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with nothing expected: %h", r);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (r.res_num !== e.res_num) begin
            $error("res_num expected %0d actual %0d", e.res_num, r.res_num);
            errors++;
         end
         if (r.res_den !== e.res_den) begin
            $error("res_den expected %0d actual %0d", e.res_den, r.res_den);
            errors++;
         end
         if (r.truth !== e.truth) begin
            $error("truth expected %0b actual %0b", e.truth, r.truth);
            errors++;
         end
         if (r.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, r.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_item = '0;
   logic rsp_strobe;
   rsp_type rsp_item;
   longint unsigned cycles = 0;
   int idle_pct = 0;
   rational_scoreboard sb = new();

   rational_arithmetic_unit_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) sb.check_result(rsp_item);
      if (cycles > 64'd100_000_000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Hold the item until accepted (start high while busy low at an edge).
   task automatic send_item(req_type q);
      while ($urandom_range(99, 0) < idle_pct) @(posedge clock);
      start <= 1;
      req_item <= q;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(q);
      start <= 0;
      // wait for busy to rise so the next start is not taken twice
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_num(int sz);
      logic signed [31:0] v;
      case (sz)
         0: v = $urandom_range(20, 0);
         1: v = $urandom_range(5000, 0);
         default: v = $urandom;
      endcase
      if ($urandom_range(1, 0)) v = -v;
      return v;
   endfunction

   function automatic logic [30:0] rand_den(int sz);
      case (sz)
         0: return 31'($urandom_range(20, 1));
         1: return 31'($urandom_range(5000, 1));
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic req_type rand_req();
      req_type q;
      int sz;
      sz = $urandom_range(3, 0);
      if (sz == 3) sz = 2;
      q.op = $urandom_range(15, 0) < 14 ? 4'($urandom_range(9, 0))
                                        : 4'($urandom_range(15, 10));
      q.a_num = rand_num(sz);
      q.b_num = rand_num($urandom_range(2, 0));
      q.a_den = rand_den(sz);
      q.b_den = rand_den($urandom_range(2, 0));
      case ($urandom_range(19, 0))
         0: q.a_den = '0;
         1: q.b_den = '0;
         2: q.b_num = '0;
         3: q.b_den = q.a_den;
         4: begin
            q.b_num = q.a_num;
            q.b_den = q.a_den;
         end
         default: ;
      endcase
      return q;
   endfunction

   function automatic req_type mk(op_type o, int an, int ad, int bn, int bd);
      req_type q;
      q.op = o;
      q.a_num = an;
      q.a_den = 31'(ad);
      q.b_num = bn;
      q.b_den = 31'(bd);
      return q;
   endfunction

   initial begin
      req_type q;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: every op, extremes, zero denominators, divide by zero,
      // overflow, -2^31, unreduced operands, unused op codes, zero result
      for (int o = 0; o <= 9; o++) send_item(mk(op_type'(o), 1, 2, -1, 3));
      send_item(mk(OP_DIV, 5, 7, 0, 3));
      send_item(mk(OP_ADD, 1, 0, 1, 1));
      send_item(mk(OP_LT, 1, 1, 1, 0));
      send_item(mk(OP_MUL, 2147483647, 1, 2147483647, 1));
      send_item(mk(OP_ADD, 32'h8000_0000, 1, 32'h8000_0000, 1));
      send_item(mk(OP_SUB, 3, 4, 3, 4));
      send_item(mk(OP_ADD, 1, 2147483647, 1, 2147483646));
      send_item(mk(OP_DIV, 32'h8000_0000, 2147483647, -1, 2147483647));
      send_item(mk(OP_MUL, 6, 4, 10, 8));
      send_item(mk(OP_GE, -2147483647, 2147483647, 32'h8000_0000, 1));
      q = mk(OP_ADD, 0, 1, 0, 1);
      q.op = 4'd15;
      send_item(q);
      q.op = 4'd10;
      send_item(q);
      send_item(mk(OP_EQ, 2, 4, 1, 2));
      // random phases with varied sender idling
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: idle_pct = 0;
            1: idle_pct = 45;
            2: idle_pct = 23;
            default: idle_pct = 0;
         endcase
         for (int i = 0; i < 280; i++) send_item(rand_req());
      end
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ----- rational_arithmetic_unit_core.f -----
rtl/rau_pkg.sv
rtl/rau_div.sv
rtl/rational_arithmetic_unit_core.sv
dv/rational_arithmetic_unit_core_test.sv
